@@ src/plb_pkg.sv @@
package plb_pkg;

    localparam int POWER_BITS  = 8;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 18;

    localparam logic [15:0] ONE_Q15  = 16'd32768;
    localparam logic [15:0] CHAN_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CFG_DIFFUSE  = 2'd0,
        CFG_SPECULAR = 2'd1,
        CFG_POWER    = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0][15:0] light;
        logic [2:0][15:0] acc;
        logic             lit;
        logic [48:0]      num;
    } t_side;

endpackage

@@ src/plb_in_if.sv @@
interface plb_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic        [15:0] light_red;
    logic        [15:0] light_green;
    logic        [15:0] light_blue;
    logic        [15:0] acc_red;
    logic        [15:0] acc_green;
    logic        [15:0] acc_blue;

    modport source (
        output valid, normal_x, normal_y, normal_z, dir_x, dir_y, dir_z,
        output light_red, light_green, light_blue, acc_red, acc_green, acc_blue,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, dir_x, dir_y, dir_z,
        input  light_red, light_green, light_blue, acc_red, acc_green, acc_blue,
        output ready
    );
endinterface

@@ src/plb_out_if.sv @@
interface plb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic        lit;

    modport source (output valid, out_red, out_green, out_blue, lit, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, lit, output ready);
endinterface

@@ src/plb_isqrt.sv @@
module plb_isqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [63:0]          i_x,
    input  plb_pkg::t_side       i_side,
    output logic                 o_valid,
    output logic [31:0]          o_root,
    output plb_pkg::t_side       o_side
);
    localparam int N = plb_pkg::SQRT_STAGES;

    logic           w_v    [0:N];
    logic [32:0]    w_rem  [0:N];
    logic [31:0]    w_root [0:N];
    logic [63:0]    w_x    [0:N];
    plb_pkg::t_side w_side [0:N];

    assign w_v[0]    = i_valid;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_x[0]    = i_x;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < N; k++) begin : g_st
        logic           r_v;
        logic [32:0]    r_rem;
        logic [31:0]    r_root;
        logic [63:0]    r_x;
        plb_pkg::t_side r_side;
        logic [34:0]    w_t;
        logic [34:0]    w_trial;

        always_comb begin
            w_t     = {w_rem[k], w_x[k][63:62]};
            w_trial = {1'b0, w_root[k], 2'b01};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
            if (i_en) begin
                if (w_t >= w_trial) begin
                    r_rem  <= w_t[32:0] - w_trial[32:0];
                    r_root <= {w_root[k][30:0], 1'b1};
                end else begin
                    r_rem  <= w_t[32:0];
                    r_root <= {w_root[k][30:0], 1'b0};
                end
                r_x    <= {w_x[k][61:0], 2'b00};
                r_side <= w_side[k];
            end
        end

        assign w_v[k+1]    = r_v;
        assign w_rem[k+1]  = r_rem;
        assign w_root[k+1] = r_root;
        assign w_x[k+1]    = r_x;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[N];
    assign o_root  = w_root[N];
    assign o_side  = w_side[N];
endmodule

@@ src/phong_light_blend.sv @@
// Phong light blend: adds one light's diffuse and specular share to a running color.
//
// Input channel i_in (valid/ready) carries the normal, light direction, light color
// and running color of one item; output channel o_out returns the new color and the
// lit flag, one beat per input beat, in order.
// Configuration: i_cfg_we with i_cfg_idx/i_cfg_data writes diffuse gain (0), specular
// gain (1) or specular power (2); write only while the pipe is empty.
//
// Throughput: one beat per cycle unless the output stalls. Stages in order:
// the product and sum registers, 32 square-root stages (one result bit each),
// 18 divider stages (one quotient bit each), POWER_BITS stages for the
// square-and-multiply ladder, and the gain product and saturation registers.
//
// Reset clears all valid bits and loads the register defaults (diffuse 1.0,
// specular 0, power 1). When the receiver holds ready low with a result waiting,
// the whole pipe freezes and i_in.ready drops; nothing is lost or repeated.
module phong_light_blend #(
    parameter int POWER_BITS = plb_pkg::POWER_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    plb_in_if.sink      i_in,
    plb_out_if.source   o_out
);
    localparam int ND = plb_pkg::DIV_STAGES;

    logic [15:0] r_diff, r_spec;
    logic [7:0]  r_spow;
    logic        w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff <= plb_pkg::ONE_Q15;
            r_spec <= '0;
            r_spow <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                plb_pkg::CFG_DIFFUSE:  r_diff <= i_cfg_data;
                plb_pkg::CFG_SPECULAR: r_spec <= i_cfg_data;
                plb_pkg::CFG_POWER:    r_spow <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic r_ov;
    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    // products
    logic                r_s1_v;
    logic signed [47:0]  r_nd [3];
    logic        [63:0]  r_sq [3];
    plb_pkg::t_side      r_s1_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_in.valid;
        end
        if (w_en) begin
            r_nd[0] <= 48'(i_in.normal_x * i_in.dir_x);
            r_nd[1] <= 48'(i_in.normal_y * i_in.dir_y);
            r_nd[2] <= 48'(i_in.normal_z * i_in.dir_z);
            r_sq[0] <= 64'(64'(i_in.dir_x) * 64'(i_in.dir_x));
            r_sq[1] <= 64'(64'(i_in.dir_y) * 64'(i_in.dir_y));
            r_sq[2] <= 64'(64'(i_in.dir_z) * 64'(i_in.dir_z));
            r_s1_side.light <= {i_in.light_blue, i_in.light_green, i_in.light_red};
            r_s1_side.acc   <= {i_in.acc_blue, i_in.acc_green, i_in.acc_red};
            r_s1_side.lit   <= 1'b0;
            r_s1_side.num   <= '0;
        end
    end

    // sums
    logic               r_s2_v;
    logic [63:0]        r_s2_s;
    plb_pkg::t_side     r_s2_side;
    logic signed [49:0] w_dot;

    always_comb begin
        w_dot = 50'(r_nd[0]) + 50'(r_nd[1]) + 50'(r_nd[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
        if (w_en) begin
            r_s2_s          <= r_sq[0] + r_sq[1] + r_sq[2];
            r_s2_side.light <= r_s1_side.light;
            r_s2_side.acc   <= r_s1_side.acc;
            r_s2_side.lit   <= !w_dot[49] && (w_dot != '0);
            r_s2_side.num   <= {w_dot[47:0], 1'b0};
        end
    end

    logic           w_sq_v;
    logic [31:0]    w_root;
    plb_pkg::t_side w_sq_side;

    plb_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_v),
        .i_x     (r_s2_s),
        .i_side  (r_s2_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // divider: cos = 2*dot / r, quotient fits 18 bits
    logic           w_dv   [0:ND];
    logic [31:0]    w_drem [0:ND];
    logic [17:0]    w_dlo  [0:ND];
    logic [17:0]    w_q    [0:ND];
    logic [31:0]    w_dvs  [0:ND];
    plb_pkg::t_side w_dside[0:ND];

    assign w_dv[0]    = w_sq_v;
    assign w_drem[0]  = {1'b0, w_sq_side.num[48:18]};
    assign w_dlo[0]   = w_sq_side.num[17:0];
    assign w_q[0]     = '0;
    assign w_dvs[0]   = w_root;
    assign w_dside[0] = w_sq_side;

    for (genvar k = 0; k < ND; k++) begin : g_div
        logic           r_v;
        logic [31:0]    r_rem;
        logic [17:0]    r_lo;
        logic [17:0]    r_q;
        logic [31:0]    r_dvs;
        plb_pkg::t_side r_side;
        logic [32:0]    w_t;
        logic           w_ge;

        always_comb begin
            w_t  = {w_drem[k], w_dlo[k][17]};
            w_ge = w_t >= {1'b0, w_dvs[k]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= w_dv[k];
            end
            if (w_en) begin
                r_rem  <= w_ge ? 32'(w_t - {1'b0, w_dvs[k]}) : w_t[31:0];
                r_q    <= {w_q[k][16:0], w_ge};
                r_lo   <= {w_dlo[k][16:0], 1'b0};
                r_dvs  <= w_dvs[k];
                r_side <= w_dside[k];
            end
        end

        assign w_dv[k+1]    = r_v;
        assign w_drem[k+1]  = r_rem;
        assign w_dlo[k+1]   = r_lo;
        assign w_q[k+1]     = r_q;
        assign w_dvs[k+1]   = r_dvs;
        assign w_dside[k+1] = r_side;
    end

    // square-and-multiply ladder
    logic [POWER_BITS-1:0] w_e;
    logic                  w_pv   [0:POWER_BITS];
    logic [15:0]           w_pr   [0:POWER_BITS];
    logic [15:0]           w_base [0:POWER_BITS];
    logic [15:0]           w_cos  [0:POWER_BITS];
    plb_pkg::t_side        w_pside[0:POWER_BITS];

    assign w_e        = POWER_BITS'(r_spow);
    assign w_pv[0]    = w_dv[ND];
    assign w_pr[0]    = plb_pkg::ONE_Q15;
    assign w_cos[0]   = (w_q[ND] > 18'(plb_pkg::ONE_Q15)) ? plb_pkg::ONE_Q15 : w_q[ND][15:0];
    assign w_base[0]  = w_cos[0];
    assign w_pside[0] = w_dside[ND];

    for (genvar k = 0; k < POWER_BITS; k++) begin : g_pow
        logic           r_v;
        logic [15:0]    r_pr;
        logic [15:0]    r_base;
        logic [15:0]    r_cos;
        plb_pkg::t_side r_side;
        logic [31:0]    w_pm;
        logic [31:0]    w_bm;

        always_comb begin
            w_pm = 32'(w_pr[k]) * 32'(w_base[k]);
            w_bm = 32'(w_base[k]) * 32'(w_base[k]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (w_en) begin
                r_v <= w_pv[k];
            end
            if (w_en) begin
                r_pr   <= w_e[k] ? w_pm[30:15] : w_pr[k];
                r_base <= w_bm[30:15];
                r_cos  <= w_cos[k];
                r_side <= w_pside[k];
            end
        end

        assign w_pv[k+1]    = r_v;
        assign w_pr[k+1]    = r_pr;
        assign w_base[k+1]  = r_base;
        assign w_cos[k+1]   = r_cos;
        assign w_pside[k+1] = r_side;
    end

    // gain products
    logic             r_g1_v, r_g2_v;
    logic [31:0]      r_lg [3];
    logic [31:0]      r_ls [3];
    logic [15:0]      r_g1_cos, r_g1_pw;
    logic [17:0]      r_dt [3];
    logic [17:0]      r_st [3];
    logic [2:0][15:0] r_g1_acc, r_g2_acc;
    logic             r_g1_lit, r_g2_lit;
    plb_pkg::t_side   w_ps;

    assign w_ps = w_pside[POWER_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_v <= 1'b0;
            r_g2_v <= 1'b0;
        end else if (w_en) begin
            r_g1_v <= w_pv[POWER_BITS];
            r_g2_v <= r_g1_v;
        end
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_lg[i] <= 32'(w_ps.light[i]) * 32'(r_diff);
                r_ls[i] <= 32'(w_ps.light[i]) * 32'(r_spec);
                r_dt[i] <= 18'((48'(r_lg[i]) * 48'(r_g1_cos)) >> 30);
                r_st[i] <= 18'((48'(r_ls[i]) * 48'(r_g1_pw)) >> 30);
            end
            r_g1_cos <= w_cos[POWER_BITS];
            r_g1_pw  <= w_pr[POWER_BITS];
            r_g1_acc <= w_ps.acc;
            r_g1_lit <= w_ps.lit;
            r_g2_acc <= r_g1_acc;
            r_g2_lit <= r_g1_lit;
        end
    end

    // sum, saturate, output register
    logic [2:0][15:0] r_out;
    logic             r_olit;
    logic [2:0][15:0] n_out;
    logic [18:0]      w_sum [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = 19'(r_g2_acc[i]) + 19'(r_dt[i]) + 19'(r_st[i]);
            if (!r_g2_lit) begin
                n_out[i] = r_g2_acc[i];
            end else if (w_sum[i] > 19'(plb_pkg::CHAN_MAX)) begin
                n_out[i] = plb_pkg::CHAN_MAX;
            end else begin
                n_out[i] = w_sum[i][15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_g2_v;
        end
        if (w_en) begin
            r_out  <= n_out;
            r_olit <= r_g2_lit;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_red   = r_out[0];
    assign o_out.out_green = r_out[1];
    assign o_out.out_blue  = r_out[2];
    assign o_out.lit       = r_olit;
endmodule

@@ src/plb_checker.sv @@
module plb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_red,
    input logic [15:0] i_out_green,
    input logic [15:0] i_out_blue,
    input logic        i_out_lit
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while output stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_red)
        && $stable(i_out_green) && $stable(i_out_blue) && $stable(i_out_lit))
        else $error("stalled output beat changed");
endmodule

bind phong_light_blend plb_checker u_plb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_red   (o_out.out_red),
    .i_out_green (o_out.out_green),
    .i_out_blue  (o_out.out_blue),
    .i_out_lit   (o_out.lit)
);

@@ dv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT = 55 + plb_pkg::POWER_BITS;
    localparam int WDOG_LIMIT = 20000;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        lit;
    } t_color;

    typedef struct {
        logic signed [15:0] n [3];
        logic signed [31:0] d [3];
        logic [15:0] light [3];
        logic [15:0] acc [3];
    } t_shade;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = plb_pkg::CFG_DIFFUSE;
    logic [15:0] i_cfg_data = '0;

    plb_in_if  in_ch ();
    plb_out_if out_ch ();

    phong_light_blend uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    logic [15:0] diffuse_gain;
    logic [15:0] specular_gain;
    logic [7:0]  specular_power;

    t_color expected_colors [$];
    int     mismatches = 0;
    bit     idle_en = 1'b1;
    bit     hold_off = 1'b0;
    int     stall_cycles = 0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.normal_x = '0;
        in_ch.normal_y = '0;
        in_ch.normal_z = '0;
        in_ch.dir_x = '0;
        in_ch.dir_y = '0;
        in_ch.dir_z = '0;
        in_ch.light_red = '0;
        in_ch.light_green = '0;
        in_ch.light_blue = '0;
        in_ch.acc_red = '0;
        in_ch.acc_green = '0;
        in_ch.acc_blue = '0;
    end

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_color shade_color(t_shade s);
        t_color c;
        logic signed [63:0] dot;
        logic [63:0] sq, mg, r, cosq, pw, base, lt, dt, st, sum;
        logic [15:0] ch [3];
        dot = 0;
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            dot += 64'(s.n[i]) * 64'(s.d[i]);
            mg = s.d[i] < 0 ? -64'(s.d[i]) : 64'(s.d[i]);
            sq += mg * mg;
        end
        if (dot <= 0) begin
            c.red = s.acc[0];
            c.green = s.acc[1];
            c.blue = s.acc[2];
            c.lit = 1'b0;
            return c;
        end
        r = root64(sq);
        if (r == 0) cosq = 32768;
        else begin
            cosq = (64'(dot) * 2) / r;
            if (cosq > 32768) cosq = 32768;
        end
        pw = 32768;
        base = cosq;
        for (int i = 0; i < plb_pkg::POWER_BITS; i++) begin
            if (specular_power[i]) pw = (pw * base) >> 15;
            base = (base * base) >> 15;
        end
        for (int i = 0; i < 3; i++) begin
            lt = s.light[i];
            dt = (lt * diffuse_gain * cosq) >> 30;
            st = (lt * specular_gain * pw) >> 30;
            sum = s.acc[i] + dt + st;
            ch[i] = sum > 65535 ? 16'hFFFF : sum[15:0];
        end
        c.red = ch[0];
        c.green = ch[1];
        c.blue = ch[2];
        c.lit = 1'b1;
        return c;
    endfunction

    task automatic write_reg(plb_pkg::t_cfg_idx idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            plb_pkg::CFG_DIFFUSE:  diffuse_gain = val;
            plb_pkg::CFG_SPECULAR: specular_gain = val;
            default:               specular_power = val[7:0];
        endcase
    endtask

    task automatic drain();
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_gains(logic [15:0] dg, logic [15:0] sg, logic [7:0] pw);
        drain();
        write_reg(plb_pkg::CFG_DIFFUSE, dg);
        write_reg(plb_pkg::CFG_SPECULAR, sg);
        write_reg(plb_pkg::CFG_POWER, {8'h00, pw});
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_shade(t_shade s);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.normal_x <= s.n[0];
        in_ch.normal_y <= s.n[1];
        in_ch.normal_z <= s.n[2];
        in_ch.dir_x <= s.d[0];
        in_ch.dir_y <= s.d[1];
        in_ch.dir_z <= s.d[2];
        in_ch.light_red <= s.light[0];
        in_ch.light_green <= s.light[1];
        in_ch.light_blue <= s.light[2];
        in_ch.acc_red <= s.acc[0];
        in_ch.acc_green <= s.acc[1];
        in_ch.acc_blue <= s.acc[2];
        do @(posedge i_clk); while (!in_ch.ready);
        expected_colors.push_back(shade_color(s));
    endtask

    task automatic end_burst();
        in_ch.valid <= 1'b0;
    endtask

    function automatic t_shade rand_shade();
        t_shade s;
        int unsigned mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            s.n[i] = 16'(int'($urandom_range(0, 32768)) - 16384);
            case (mode)
                0: s.d[i] = $urandom;
                1, 2: s.d[i] = $signed($urandom_range(0, 2 * 65536)) - 65536;
                3: s.d[i] = $signed($urandom_range(0, 64)) - 32;
                default: s.d[i] = $signed($urandom_range(0, 2 * 2097152)) - 2097152;
            endcase
            s.light[i] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1024));
            s.acc[i] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8192));
        end
        return s;
    endfunction

    function automatic t_shade make_shade(int nx, int ny, int nz, int dx, int dy, int dz,
                                          logic [15:0] lt, logic [15:0] ac);
        t_shade s;
        s.n[0] = 16'(nx); s.n[1] = 16'(ny); s.n[2] = 16'(nz);
        s.d[0] = dx; s.d[1] = dy; s.d[2] = dz;
        for (int i = 0; i < 3; i++) begin
            s.light[i] = lt + 16'(i * 7);
            s.acc[i] = ac + 16'(i * 3);
        end
        return s;
    endfunction

    task automatic test_directed();
        send_shade(make_shade(0, 0, 16384, 0, 0, 65536, 16'h0100, 16'h0000));
        send_shade(make_shade(0, 0, -16384, 0, 0, 65536, 16'h0100, 16'h1234));
        send_shade(make_shade(16384, 0, 0, 0, 0, 0, 16'hFFFF, 16'h4321));
        send_shade(make_shade(16384, 16384, 16384, 65536, 65536, 65536, 16'hFFFF, 16'hFFF0));
        send_shade(make_shade(1, 0, 0, 1, 2147483647, 0, 16'hFFFF, 16'h0000));
        send_shade(make_shade(-16384, -16384, -16384, -2147483647 - 1, -2147483647 - 1,
                              -2147483647 - 1, 16'hFFFF, 16'hFFFF));
        send_shade(make_shade(16384, -16384, 16384, 2147483647, -2147483647 - 1,
                              2147483647, 16'h8000, 16'h0001));
        send_shade(make_shade(16384, 0, 0, 1, 0, 0, 16'h0000, 16'h0000));
        send_shade(make_shade(11585, 11585, 0, 65536, 0, 0, 16'hFFFF, 16'h0000));
        send_shade(make_shade(0, 16384, 0, 3, -7, 1, 16'h7FFF, 16'h8000));
        send_shade(make_shade(-16384, 0, 0, 0, 0, -5, 16'h0010, 16'h0020));
        end_burst();
    endtask

    task automatic test_config_sweep();
        logic [15:0] dgs [4] = '{16'd0, 16'd65535, 16'd32768, 16'd12345};
        logic [15:0] sgs [4] = '{16'd65535, 16'd0, 16'd32768, 16'd40000};
        logic [7:0]  pws [4] = '{8'd0, 8'd255, 8'd1, 8'd32};
        for (int k = 0; k < 4; k++) begin
            set_gains(dgs[k], sgs[k], pws[k]);
            repeat (60) send_shade(rand_shade());
            end_burst();
        end
    endtask

    task automatic test_random();
        for (int k = 0; k < 8; k++) begin
            set_gains(16'($urandom), 16'($urandom), 8'($urandom));
            repeat (125) send_shade(rand_shade());
            end_burst();
        end
    endtask

    task automatic test_backpressure();
        set_gains(16'd30000, 16'd20000, 8'd16);
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (150) send_shade(rand_shade());
        join
        end_burst();
        drain();
        repeat (20) send_shade(rand_shade());
        end_burst();
    endtask

    task automatic test_full_rate();
        idle_en = 1'b0;
        set_gains(16'd32768, 16'd16384, 8'd8);
        repeat (100) send_shade(rand_shade());
        end_burst();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_cycles <= 0;
        end else if (hold_off) begin
            out_ch.ready <= 1'b0;
        end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            out_ch.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_cycles <= $urandom_range(0, 5);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_color exp_c;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected beat: red %h green %h blue %h lit %b", $time,
                         out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.lit);
                mismatches++;
            end else begin
                exp_c = expected_colors.pop_front();
                if (out_ch.out_red !== exp_c.red || out_ch.out_green !== exp_c.green ||
                    out_ch.out_blue !== exp_c.blue || out_ch.lit !== exp_c.lit) begin
                    $display("%0t: expected red %h green %h blue %h lit %b, got %h %h %h %b",
                             $time, exp_c.red, exp_c.green, exp_c.blue, exp_c.lit,
                             out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.lit);
                    mismatches++;
                end
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        diffuse_gain = 16'd32768;
        specular_gain = 16'd0;
        specular_power = 8'd1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_sweep();
        test_random();
        test_backpressure();
        test_full_rate();
        while (expected_colors.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ files.f @@
src/plb_pkg.sv
src/plb_in_if.sv
src/plb_out_if.sv
src/plb_isqrt.sv
src/phong_light_blend.sv
src/plb_checker.sv
dv/tb.sv
